FILE: rtl/core/kgr_pkg.sv
// ----------------------------------------------------------------------------
// kgr_pkg
// Shared types and constants for the kanji glyph memory port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kgr_pkg;

  localparam int ADDR_W = 19;

  typedef enum logic [2:0] {
    ACT_CODE_LO = 3'd0,
    ACT_CODE_HI = 3'd1,
    ACT_READ    = 3'd2,
    ACT_WRITE   = 3'd3,
    ACT_ROW     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_ROM   = 2'd1,
    TGT_RAM   = 2'd2,
    TGT_SOLID = 2'd3
  } target_t;

  localparam logic [0:0] REG_ANK_EIGHT_DOT = 1'b0;

  // JIS block boundaries on the first byte
  localparam logic [7:0] J1_OFS     = 8'h20;
  localparam logic [7:0] J1_BLK28   = 8'h28;
  localparam logic [7:0] J1_BLK30   = 8'h30;
  localparam logic [7:0] J1_BLK40   = 8'h40;
  localparam logic [7:0] J1_BLK50   = 8'h50;
  localparam logic [7:0] J1_BLK60   = 8'h60;
  localparam logic [7:0] J1_BLK70   = 8'h70;
  localparam logic [7:0] J1_USER    = 8'h76;
  localparam logic [7:0] J1_USER_HI = 8'h77;
  localparam logic [7:0] J1_END     = 8'h78;
  localparam logic [6:0] J2_SOLID0  = 7'h7E;
  localparam logic [6:0] J2_SOLID1  = 7'h7F;

  localparam logic [ADDR_W-1:0] ANK16_BASE = 19'h40000;
  localparam logic [ADDR_W-1:0] ANK8_BASE  = 19'h41000;
  localparam logic [ADDR_W-1:0] BASE_40000 = 19'h40000;
  localparam logic [ADDR_W-1:0] BASE_04000 = 19'h04000;
  localparam logic [ADDR_W-1:0] BASE_20000 = 19'h20000;
  localparam logic [ADDR_W-1:0] BASE_24000 = 19'h24000;

  localparam logic [7:0] SOLID_BYTE = 8'hFF;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_data;
  } req_word_t;

  typedef struct packed {
    logic [1:0]        mem_target;
    logic [ADDR_W-1:0] mem_address;
    logic              mem_write;
    logic [7:0]        write_byte;
    logic [7:0]        fallback_byte;
  } rsp_word_t;

  typedef struct packed {
    target_t           target;
    logic [ADDR_W-1:0] base;
  } dec_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/kgr_decode.sv
// ----------------------------------------------------------------------------
// kgr_decode
// Maps a hardware character code to memory target and glyph base address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kgr_decode (
  input  wire logic [15:0]          code,
  input  wire logic                 ank_eight_dot,
  output kgr_pkg::dec_result_t      dec
);
  import kgr_pkg::*;

  logic                 lr;
  logic [7:0]           j1;
  logic [6:0]           j2;
  logic [ADDR_W-1:0]    lo;
  logic [ADDR_W-1:0]    hi8;
  logic [ADDR_W-1:0]    hi10;
  logic [ADDR_W-1:0]    hi6;
  logic [ADDR_W-1:0]    j1_3;
  logic [ADDR_W-1:0]    j1_4;
  logic [ADDR_W-1:0]    j1_1;
  logic [ADDR_W-1:0]    lr_w;

  assign lr   = code[15];
  assign j1   = {1'b0, code[6:0]} + J1_OFS;
  assign j2   = code[14:8];
  assign lr_w = ADDR_W'(lr);
  assign lo   = ADDR_W'({j2[4:0], 5'd0});
  assign hi8  = ADDR_W'({j2[6:5], 13'd0});
  assign hi10 = ADDR_W'({j2[6:5], 15'd0});
  assign hi6  = ADDR_W'({j2[6:5], 11'd0});
  assign j1_3 = ADDR_W'({j1[2:0], 10'd0});
  assign j1_4 = ADDR_W'({j1[3:0], 10'd0});
  assign j1_1 = ADDR_W'({j1[0], 10'd0});

  always_comb begin
    dec.target = TGT_ROM;
    dec.base   = '0;
    if (j2 == 7'd0 && !lr) begin
      if (ank_eight_dot) begin
        dec.base = ANK8_BASE + ADDR_W'({code[7:0], 3'd0});
      end else begin
        dec.base = ANK16_BASE + ADDR_W'({code[7:0], 4'd0});
      end
    end else if (j1 < J1_BLK28) begin
      dec.base = lr_w + hi8 + j1_3 + lo;
    end else if (j1 < J1_BLK30) begin
      dec.base = lr_w + BASE_40000 + hi8 + j1_3 + lo;
    end else if (j1 < J1_BLK40) begin
      dec.base = lr_w + hi10 + j1_4 + lo;
    end else if (j1 < J1_BLK50) begin
      dec.base = lr_w + BASE_04000 + hi10 + j1_4 + lo;
    end else if (j1 < J1_BLK60) begin
      dec.base = lr_w + BASE_20000 + hi10 + j1_4 + lo;
    end else if (j1 < J1_BLK70) begin
      dec.base = lr_w + BASE_24000 + hi10 + j1_4 + lo;
    end else if (j1 < J1_USER) begin
      dec.base = lr_w + BASE_20000 + hi8 + j1_3 + lo;
    end else if (j1 < J1_END) begin
      if (j1 == J1_USER_HI && (j2 == J2_SOLID0 || j2 == J2_SOLID1)) begin
        dec.target = TGT_SOLID;
        dec.base   = lr_w;
      end else begin
        dec.target = TGT_RAM;
        dec.base   = lr_w + hi6 + j1_1 + lo;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/kanji_glyph_rom_port.sv
// ----------------------------------------------------------------------------
// kanji_glyph_rom_port
// Character-generator port: code/row registers, glyph decode, result register.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one bus access word:
//   code low byte, code high byte, row register load, glyph read or glyph
//   write. Every accepted word yields exactly one rsp word (rsp_valid/
//   rsp_ready/rsp) with memory target, byte address, write strobe, write byte
//   and fallback byte. Register loads and unused actions give an all-zero rsp.
//   The rsp word is registered: it is valid the cycle after acceptance.
//   Throughput is one word per cycle, set by the single rsp register; while
//   rsp_ready is low and a rsp word is held, req_ready drops and no word is
//   taken. The rsp word holds until taken.
//   The APB port holds ank_eight_dot at byte address 0 (paddr[2] low).
//   Reset (rst, synchronous) clears the character code, row register,
//   ank_eight_dot and rsp_valid; the block is ready in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kanji_glyph_rom_port (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire kgr_pkg::req_word_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output kgr_pkg::rsp_word_t      rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import kgr_pkg::*;

  logic              ank_eight_dot;
  logic [14:0]       char_code;
  logic [7:0]        row_select;
  logic [14:0]       char_code_next;
  logic [7:0]        row_select_next;
  rsp_word_t         rsp_next;
  logic              accept;
  logic [15:0]       hw_code;
  dec_result_t       dec;
  logic [3:0]        row_rd;
  logic [3:0]        row_wr;
  logic              wide;
  logic [4:0]        ofs_rd;
  logic [4:0]        ofs_wr;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2:2] == REG_ANK_EIGHT_DOT) ? {31'd0, ank_eight_dot} : 32'd0;
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign hw_code   = {~row_select[5], char_code};

  kgr_decode u_decode (
    .code          (hw_code),
    .ank_eight_dot (ank_eight_dot),
    .dec           (dec)
  );

  assign wide   = |char_code[14:8];
  assign row_wr = row_select[3:0];
  assign row_rd = (hw_code[15:8] == 8'd0 && ank_eight_dot) ? {1'b0, row_select[2:0]}
                                                           : row_select[3:0];
  assign ofs_rd = wide ? {row_rd, 1'b0} : {1'b0, row_rd};
  assign ofs_wr = wide ? {row_wr, 1'b0} : {1'b0, row_wr};

  always_comb begin
    char_code_next  = char_code;
    row_select_next = row_select;
    rsp_next        = '0;
    case (req.action)
      ACT_CODE_LO: begin
        char_code_next = {char_code[14:8], req.bus_data};
      end
      ACT_CODE_HI: begin
        char_code_next = {req.bus_data[6:0], char_code[7:0]};
      end
      ACT_ROW: begin
        row_select_next = req.bus_data;
      end
      ACT_READ: begin
        rsp_next.mem_target  = dec.target;
        rsp_next.mem_address = dec.base + ADDR_W'(ofs_rd);
        if (dec.target == TGT_SOLID) begin
          rsp_next.fallback_byte = SOLID_BYTE;
        end
      end
      ACT_WRITE: begin
        if (dec.target == TGT_RAM) begin
          rsp_next.mem_target  = TGT_RAM;
          rsp_next.mem_address = dec.base + ADDR_W'(ofs_wr);
          rsp_next.mem_write   = 1'b1;
          rsp_next.write_byte  = req.bus_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ank_eight_dot <= 1'b0;
      char_code     <= '0;
      row_select    <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:2] == REG_ANK_EIGHT_DOT) begin
        ank_eight_dot <= pwdata[0];
      end
      if (accept) begin
        char_code  <= char_code_next;
        row_select <= row_select_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_write_is_ram: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.mem_write |-> rsp.mem_target == TGT_RAM)
    else $error("write strobe outside backup RAM");

  a_fallback_solid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.fallback_byte != 8'd0 |-> rsp.mem_target == TGT_SOLID)
    else $error("fallback byte without fallback target");

  a_load_no_access: assert property (@(posedge clk) disable iff (rst)
    accept && (req.action == ACT_CODE_LO || req.action == ACT_CODE_HI ||
               req.action == ACT_ROW)
    |=> rsp_valid && rsp.mem_target == TGT_NONE && !rsp.mem_write)
    else $error("register load produced a memory access");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("not ready with empty result register");

  a_wbyte_needs_strobe: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.write_byte != 8'd0 |-> rsp.mem_write)
    else $error("write byte without write strobe");

endmodule

`default_nettype wire
